// File: sv/trilinear_3d_lut_interpolator_defines.svh
// Assertion macros for the trilinear 3D LUT interpolator.
// Used by the port checker; depends on nothing else.
`ifndef TRILINEAR_3D_LUT_INTERPOLATOR_DEFINES_SVH
`define TRILINEAR_3D_LUT_INTERPOLATOR_DEFINES_SVH
// Implication checked on every clock outside reset.
`define TLI_ASSERT_IMPL(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("tli check failed");
// Next-cycle implication.
`define TLI_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("tli check failed");
`endif

// File: sv/tli_pkg.sv
// Shared constants and types for the trilinear 3D LUT interpolator.
// No dependencies.
package tli_pkg;
   localparam int LutSize   = 33;
   localparam int NodeCount = LutSize * LutSize * LutSize;
   localparam int AddrW     = $clog2(NodeCount);
   localparam int IdxW      = $clog2(LutSize);
   localparam logic [16:0] OneQ16 = 17'h10000;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_LOOKUP = 1'b1;

   typedef logic [47:0] node_type;

   // Split one coordinate into lower node, upper node and weight.
   typedef struct packed {
      logic [IdxW-1:0] lo;
      logic [IdxW-1:0] hi;
      logic [15:0]     frac;
   } axis_type;

   function automatic axis_type split_axis(input logic [16:0] coord);
      logic [16:0] c;
      logic [23:0] scaled;
      axis_type    a;
      c      = (coord > OneQ16) ? OneQ16 : coord;
      scaled = 24'(c) * 24'(LutSize - 1);
      a.lo   = IdxW'(scaled[23:16]);
      a.frac = scaled[15:0];
      a.hi   = (a.lo == IdxW'(LutSize - 1)) ? a.lo : a.lo + IdxW'(1);
      return a;
   endfunction

   // Round half up lerp of two Q0.16 values.
   function automatic logic [15:0] lerp16(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] f);
      logic [33:0] acc;
      acc = 34'(a) * 34'(OneQ16 - 17'(f)) + 34'(b) * 34'(f) + 34'd32768;
      return acc[31:16];
   endfunction
endpackage

// File: sv/tli_node_ram.sv
// Node memory: one write port, one read port, registered read data.
// Depends on tli_pkg.
module tli_node_ram import tli_pkg::*; (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  node_type         wr_data,
   input  logic [AddrW-1:0] rd_addr,
   output node_type         rd_data
);
   node_type mem [NodeCount];
   node_type rd_data_ff;

   // Write and read the node array
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

// File: sv/tli_ctrl.sv
// Lookup sequencer: reads eight corners and blends them with one lerp per channel per step.
// Depends on tli_pkg and tli_node_ram.
module tli_ctrl import tli_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic        in_func,
   input  logic [15:0] in_index,
   input  node_type    in_node,
   input  logic [16:0] in_r,
   input  logic [16:0] in_g,
   input  logic [16:0] in_b,
   output logic        out_valid,
   input  logic        out_ready,
   output node_type    out_node
);
   typedef enum logic [1:0] {S_IDLE, S_READ, S_BLEND, S_OUT} state_type;

   state_type       state_ff, state_in;
   axis_type        ar_ff, ag_ff, ab_ff;
   logic [3:0]      cnt_ff, cnt_in;        // corner read counter
   logic            rd_pend_ff;
   logic [2:0]      rd_corner_ff;
   node_type        corner_ff [8];
   node_type        res_ff;
   logic [2:0]      step_ff;
   logic            wr_en;
   logic [AddrW-1:0] rd_addr;
   node_type        rd_data;
   logic [IdxW-1:0] ri, gi, bi;
   logic            accept;

   assign accept    = in_valid && in_ready;
   assign in_ready  = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_OUT);
   assign out_node  = res_ff;
   assign wr_en     = accept && (in_func == FUNC_LOAD) && (32'(in_index) < NodeCount);

   // Corner address from counter bits: bit0 red, bit1 green, bit2 blue
   always_comb begin
      ri = cnt_ff[0] ? ar_ff.hi : ar_ff.lo;
      gi = cnt_ff[1] ? ag_ff.hi : ag_ff.lo;
      bi = cnt_ff[2] ? ab_ff.hi : ab_ff.lo;
      rd_addr = AddrW'(ri) + AddrW'(gi) * AddrW'(LutSize)
              + AddrW'(bi) * AddrW'(LutSize * LutSize);
   end

   tli_node_ram u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(in_index[AddrW-1:0]),
      .wr_data(in_node),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE:  if (accept && in_func == FUNC_LOOKUP) begin
            state_in = S_READ; cnt_in = '0;
         end
         S_READ:  begin
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd7) state_in = S_BLEND;
         end
         S_BLEND: if (step_ff == 3'd7) state_in = S_OUT;
         S_OUT:   if (out_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state, capture corners, run blend steps (one lerp per channel per step)
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         cnt_ff     <= '0;
         rd_pend_ff <= 1'b0;
         step_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rd_pend_ff <= (state_ff == S_READ);
         if (state_ff != S_BLEND) step_ff <= '0;
         else step_ff <= step_ff + 3'd1;
      end
      if (accept) begin
         ar_ff <= split_axis(in_r);
         ag_ff <= split_axis(in_g);
         ab_ff <= split_axis(in_b);
      end
      rd_corner_ff <= cnt_ff[2:0];
      if (rd_pend_ff) corner_ff[rd_corner_ff] <= rd_data;
      // Step 0: last corner lands; steps 1..7 blend per channel
      if (state_ff == S_BLEND && step_ff != 3'd0) begin
         for (int ch = 0; ch < 3; ch++) begin
            case (step_ff)
               3'd1: res_ff[ch*16 +: 16] <= lerp16(corner_ff[0][ch*16 +: 16],
                                                   corner_ff[1][ch*16 +: 16], ar_ff.frac);
               3'd2: corner_ff[0][ch*16 +: 16] <= lerp16(corner_ff[2][ch*16 +: 16],
                                                   corner_ff[3][ch*16 +: 16], ar_ff.frac);
               3'd3: corner_ff[2][ch*16 +: 16] <= lerp16(corner_ff[4][ch*16 +: 16],
                                                   corner_ff[5][ch*16 +: 16], ar_ff.frac);
               3'd4: corner_ff[4][ch*16 +: 16] <= lerp16(corner_ff[6][ch*16 +: 16],
                                                   corner_ff[7][ch*16 +: 16], ar_ff.frac);
               3'd5: corner_ff[1][ch*16 +: 16] <= lerp16(res_ff[ch*16 +: 16],
                                                   corner_ff[0][ch*16 +: 16], ag_ff.frac);
               3'd6: corner_ff[3][ch*16 +: 16] <= lerp16(corner_ff[2][ch*16 +: 16],
                                                   corner_ff[4][ch*16 +: 16], ag_ff.frac);
               3'd7: res_ff[ch*16 +: 16] <= lerp16(corner_ff[1][ch*16 +: 16],
                                                   corner_ff[3][ch*16 +: 16], ab_ff.frac);
               default: ;
            endcase
         end
      end
   end
endmodule

// File: sv/trilinear_3d_lut_interpolator.sv
// Trilinear 3D LUT interpolator, top level.
// A load writes node memory at its transfer and leaves the block ready. A lookup
// raises its result after eight corner reads through the single node-memory read
// port, a step for the last read to land, then seven lerp steps, one per cycle,
// three channels at a time. The next request is taken only the cycle after the
// result transfer. Reset clears control only; node memory is undefined.
module trilinear_3d_lut_interpolator import tli_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,   // func
   input  logic [119:0] req_tdata,   // entry_index, entry_red, entry_green, entry_blue,
                                     // coord_red, coord_green, coord_blue, zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata    // out_red, out_green, out_blue
);
   tli_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_func  (req_tuser),
      .in_index (req_tdata[15:0]),
      .in_node  ({req_tdata[63:48], req_tdata[47:32], req_tdata[31:16]}),
      .in_r     (req_tdata[80:64]),
      .in_g     (req_tdata[97:81]),
      .in_b     (req_tdata[114:98]),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_node (rsp_tdata)
   );
endmodule

// File: sv/tli_checker.sv
// Port checker for the trilinear 3D LUT interpolator, with its bind.
// Depends on trilinear_3d_lut_interpolator_defines.svh.
`include "trilinear_3d_lut_interpolator_defines.svh"
module tli_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata
);
   `TLI_ASSERT_IMPL(a_no_req_during_rsp, clock, reset, rsp_tvalid, !req_tready)
   `TLI_ASSERT_NEXT(a_load_no_rsp, clock, reset, req_tvalid && req_tready && !req_tuser, !rsp_tvalid)
   `TLI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
endmodule

bind trilinear_3d_lut_interpolator tli_checker u_tli_checker (.*);
